// ----- rtl/ffc_pkg.sv -----
// ----------------------------------------------------------------------------
// Float format converter package
// Shared action codes, the operand width and a request struct.
// ----------------------------------------------------------------------------
package ffc_pkg;

  localparam int unsigned OperandWidth = 32;

  typedef enum logic [1:0] {
    ActHalfToSingle = 2'd0,
    ActSingleToHalf = 2'd1,
    ActBf16ToSingle = 2'd2,
    ActSingleToBf16 = 2'd3
  } action_e;

  typedef struct packed {
    logic [1:0]              action;
    logic [OperandWidth-1:0] operand;
  } req_t;

endpackage

// ----- rtl/ffc_req_if.sv -----
// ----------------------------------------------------------------------------
// Float format converter request channel
// Valid/ready channel that carries one action and operand.
// ----------------------------------------------------------------------------
interface ffc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] operand;
  modport source (output valid, output action, output operand, input ready);
  modport sink (input valid, input action, input operand, output ready);
endinterface

// ----- rtl/ffc_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Float format converter result channel
// Valid/ready channel that carries one converted pattern.
// ----------------------------------------------------------------------------
interface ffc_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] converted;
  modport source (output valid, output converted, input ready);
  modport sink (input valid, input converted, output ready);
endinterface

// ----- rtl/float_format_converter.sv -----
// ----------------------------------------------------------------------------
// Float format converter
// Converts between binary16, bfloat16 and binary32 bit patterns.
// ----------------------------------------------------------------------------
// A transaction can enter every cycle while no stall holds the pipeline.
// Stage one decodes the operand and finds the half subnormal shift, stage two
// aligns and computes rounding bits, stage three rounds and packs. The result
// register stalls all stages in step while it holds a result and the sink is not ready.
module float_format_converter (
  input  logic         clk_i,
  input  logic         rst_ni,
  ffc_req_if.sink      req,
  ffc_rsp_if.source    rsp
);

  logic       adv;
  logic [2:0] vld_q;

  assign adv       = !vld_q[2] || rsp.ready;
  assign req.ready = adv;
  assign rsp.valid = vld_q[2];

  // Stage 1 registers.
  logic [1:0]  act1_q;
  logic [31:0] op1_q;
  logic [3:0]  lz1_q;

  logic [9:0] hman;
  logic [3:0] lz_d;
  assign hman = req.operand[9:0];

  always_comb begin
    lz_d = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (hman[i]) lz_d = 4'(10 - i);
    end
  end

  // Stage 2 registers.
  logic [1:0]  act2_q;
  logic [31:0] base2_q;
  logic [15:0] body2_q;
  logic        rnd2_q;
  logic        sgn2_q;
  logic        fix2_q;

  logic [31:0] base_d;
  logic [15:0] body_d;
  logic        rnd_d;
  logic        fix_d;

  always_comb begin
    logic [7:0]  ex;
    logic [22:0] man;
    logic [4:0]  hex;
    logic [9:0]  nm;
    logic [23:0] sig;
    logic [4:0]  sh;
    logic [23:0] q;
    logic [23:0] rem;
    logic [23:0] hw;
    logic [12:0] low;
    ex     = op1_q[30:23];
    man    = op1_q[22:0];
    hex    = op1_q[14:10];
    base_d = '0;
    body_d = '0;
    rnd_d  = 1'b0;
    fix_d  = 1'b0;
    nm     = '0;
    sig    = '0;
    sh     = '0;
    q      = '0;
    rem    = '0;
    hw     = '0;
    low    = '0;
    unique case (ffc_pkg::action_e'(act1_q))
      ffc_pkg::ActHalfToSingle: begin
        if (hex == 5'd0) begin
          if (op1_q[9:0] != 10'd0) begin
            nm = 10'(op1_q[9:0] << lz1_q);
            base_d = {op1_q[15], 8'(8'd113 - 8'(lz1_q)), nm, 13'd0};
          end else begin
            base_d = {op1_q[15], 31'd0};
          end
        end else if (hex == 5'h1F) begin
          base_d = {op1_q[15], 8'hFF, op1_q[9:0], 13'd0};
        end else begin
          base_d = {op1_q[15], 8'(8'(hex) + 8'd112), op1_q[9:0], 13'd0};
        end
      end
      ffc_pkg::ActSingleToHalf: begin
        fix_d = 1'b1;
        if (ex == 8'hFF) begin
          body_d = (man != 23'd0) ? 16'h7E00 : 16'h7C00;
        end else if (ex >= 8'd143) begin
          body_d = 16'h7C00;
        end else if (ex <= 8'd112) begin
          if (ex >= 8'd102) begin
            sig = {1'b1, man};
            sh  = 5'(8'd126 - ex);
            q   = sig >> sh;
            hw  = 24'd1 << (sh - 5'd1);
            rem = sig & ((24'd1 << sh) - 24'd1);
            body_d = q[15:0];
            fix_d  = 1'b0;
            rnd_d  = (rem > hw) || (rem == hw && q[0]);
          end
        end else begin
          body_d = {1'b0, 5'(ex - 8'd112), man[22:13]};
          low    = man[12:0];
          fix_d  = 1'b0;
          rnd_d  = (low > 13'h1000) || (low == 13'h1000 && man[13]);
        end
      end
      ffc_pkg::ActBf16ToSingle: begin
        base_d = {op1_q[15:0], 16'd0};
      end
      ffc_pkg::ActSingleToBf16: begin
        if (ex == 8'hFF && man != 23'd0) begin
          base_d = {16'd0, op1_q[31], 15'h7FC0};
        end else begin
          base_d = {16'd0, op1_q[31:16]};
          rnd_d  = (op1_q[15:0] > 16'h8000) ||
                   (op1_q[15:0] == 16'h8000 && op1_q[16]);
        end
      end
      default: base_d = '0;
    endcase
  end

  // Stage 3: rounding and packing.
  logic [31:0] res_q;
  logic [31:0] res_d;

  always_comb begin
    logic [15:0] b;
    b = body2_q + 16'(rnd2_q);
    unique case (ffc_pkg::action_e'(act2_q))
      ffc_pkg::ActSingleToHalf: begin
        if (!fix2_q && b >= 16'h7C00) b = 16'h7C00;
        res_d = {16'd0, sgn2_q, b[14:0]};
      end
      ffc_pkg::ActSingleToBf16: res_d = {16'd0, 16'(base2_q[15:0] + 16'(rnd2_q))};
      default: res_d = base2_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[1:0], req.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      act1_q  <= req.action;
      op1_q   <= req.operand;
      lz1_q   <= lz_d;
      act2_q  <= act1_q;
      base2_q <= base_d;
      body2_q <= body_d;
      rnd2_q  <= rnd_d;
      sgn2_q  <= op1_q[31];
      fix2_q  <= fix_d;
      res_q   <= res_d;
    end
  end

  assign rsp.converted = res_q;

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.converted))
    else $error("result changed under stall");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rsp.valid |-> req.ready)
    else $error("pipeline stalled without pending result");
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.valid && req.ready ##1 rsp.ready ##1 rsp.ready |=> rsp.valid)
    else $error("transaction lost in pipeline");
  a_half_hi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[1] && adv && act2_q == ffc_pkg::ActSingleToHalf |=> res_q[31:16] == 16'd0)
    else $error("half result upper bits not zero");

endmodule

// ----- sim/ffc_checker.sv -----
// ----------------------------------------------------------------------------
// Float format converter checker
// Watches the request and result channels, predicts each converted pattern
// from the accepted request and compares it with the result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffc_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  ffc_req_if          req,
  ffc_rsp_if          rsp,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  logic [31:0] expected_q[$];

  function automatic logic [31:0] widen_half(logic [15:0] h);
    logic [9:0] man;
    logic [7:0] ex;
    man = h[9:0];
    if (h[14:10] == 5'd0) begin
      if (man == 10'd0) return {h[15], 31'd0};
      ex = 8'd113;
      while (!man[9]) begin
        man = man << 1;
        ex = ex - 8'd1;
      end
      return {h[15], ex - 8'd1, man[8:0], 14'd0};
    end
    if (h[14:10] == 5'h1F) return {h[15], 8'hFF, man, 13'd0};
    return {h[15], 8'(h[14:10]) + 8'd112, man, 13'd0};
  endfunction

  function automatic logic [31:0] narrow_half(logic [31:0] v);
    logic [31:0] ex, man, sig, sh, q, rem, halfway, body, low;
    logic [15:0] sgn;
    sgn = {v[31], 15'd0};
    ex = 32'(v[30:23]);
    man = 32'(v[22:0]);
    if (ex == 32'hFF) return 32'(sgn | (man != 0 ? 16'h7E00 : 16'h7C00));
    if (ex >= 32'd143) return 32'(sgn | 16'h7C00);
    if (ex <= 32'd112) begin
      if (ex < 32'd102) return 32'(sgn);
      sig = man | 32'h800000;
      sh = 32'd126 - ex;
      q = sig >> sh;
      rem = sig & ((32'd1 << sh) - 1);
      halfway = 32'd1 << (sh - 1);
      if (rem > halfway || (rem == halfway && q[0])) q = q + 1;
      return 32'(sgn) | q;
    end
    body = ((ex - 32'd112) << 10) | (man >> 13);
    low = man & 32'h1FFF;
    if (low > 32'h1000 || (low == 32'h1000 && body[0])) body = body + 1;
    if (body >= 32'h7C00) body = 32'h7C00;
    return 32'(sgn) | body;
  endfunction

  function automatic logic [31:0] narrow_bf16(logic [31:0] v);
    logic [31:0] sum;
    if (v[30:23] == 8'hFF && v[22:0] != 23'd0) return {16'd0, v[31], 15'h7FC0};
    sum = v + 32'h7FFF + 32'(v[16]);
    return {16'd0, sum[31:16]};
  endfunction

  function automatic logic [31:0] convert(ffc_pkg::action_e act, logic [31:0] op);
    case (act)
      ffc_pkg::ActHalfToSingle: return widen_half(op[15:0]);
      ffc_pkg::ActSingleToHalf: return narrow_half(op);
      ffc_pkg::ActBf16ToSingle: return {op[15:0], 16'd0};
      default:                  return narrow_bf16(op);
    endcase
  endfunction

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    logic [31:0] want;
    if (!rst_ni) begin
      fail_count_o <= 0;
    end else begin
      if (req.valid && req.ready) begin
        expected_q.push_back(convert(ffc_pkg::action_e'(req.action), req.operand));
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_q.size() == 0) begin
          $error("converted: unexpected transaction, actual %h", rsp.converted);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_q.pop_front();
          if (rsp.converted !== want) begin
            $error("converted: expected %h, actual %h", want, rsp.converted);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

// ----- sim/float_format_converter_test.sv -----
// ----------------------------------------------------------------------------
// Float format converter testbench
// Drives directed edge cases and random requests of all four actions under
// varying source and sink stalls; a checker predicts and compares results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module float_format_converter_test;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  ffc_req_if req ();
  ffc_rsp_if rsp ();

  float_format_converter DUT (.clk_i(clk_i), .rst_ni(rst_ni), .req(req), .rsp(rsp));

  ffc_checker checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni), .req(req), .rsp(rsp),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    req.valid = 1'b0;
    req.action = 2'd0;
    req.operand = 32'd0;
    rsp.ready = 1'b0;
    send_idle_pct = 28;
    recv_idle_pct = 64;
  end

  always @(negedge clk_i) begin
    rsp.ready <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send(ffc_pkg::action_e act, logic [31:0] op);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk_i);
    end
    req.valid <= 1'b1;
    req.action <= act;
    req.operand <= op;
    @(posedge clk_i iff req.ready);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] random_operand(ffc_pkg::action_e act);
    logic [31:0] op;
    op = $urandom();
    case ($urandom_range(5))
      0: op[30:23] = 8'hFF;
      1: op[30:23] = 8'($urandom_range(100, 114));
      2: op[30:23] = 8'($urandom_range(140, 144));
      3: op[12:0] = $urandom_range(1) ? 13'h1000 : 13'h0FFF;
      4: op[15:0] = {op[15], $urandom_range(1) ? 5'd0 : 5'h1F, op[9:0]};
      default: ;
    endcase
    if (act == ffc_pkg::ActSingleToBf16 && $urandom_range(3) == 0) op[15:0] = 16'h8000;
    return op;
  endfunction

  initial begin
    ffc_pkg::action_e act;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    send(ffc_pkg::ActHalfToSingle, 32'hFFFF_0000);
    send(ffc_pkg::ActHalfToSingle, 32'h0000_8000);
    send(ffc_pkg::ActHalfToSingle, 32'h0000_0001);
    send(ffc_pkg::ActHalfToSingle, 32'h0000_83FF);
    send(ffc_pkg::ActHalfToSingle, 32'h0000_7C00);
    send(ffc_pkg::ActHalfToSingle, 32'h0000_FE01);
    send(ffc_pkg::ActHalfToSingle, 32'h0000_7BFF);
    send(ffc_pkg::ActSingleToHalf, 32'h7FC0_0001);
    send(ffc_pkg::ActSingleToHalf, 32'hFF80_0000);
    send(ffc_pkg::ActSingleToHalf, 32'h4780_0000);
    send(ffc_pkg::ActSingleToHalf, 32'h477F_F000);
    send(ffc_pkg::ActSingleToHalf, 32'h3380_0001);
    send(ffc_pkg::ActSingleToHalf, 32'hB300_0000);
    send(ffc_pkg::ActSingleToHalf, 32'h387F_E000);
    send(ffc_pkg::ActSingleToHalf, 32'h8000_0001);
    send(ffc_pkg::ActSingleToHalf, 32'h3F80_3000);
    send(ffc_pkg::ActBf16ToSingle, 32'hFFFF_FFFF);
    send(ffc_pkg::ActBf16ToSingle, 32'h1234_0000);
    send(ffc_pkg::ActSingleToBf16, 32'hFF80_0001);
    send(ffc_pkg::ActSingleToBf16, 32'h7F7F_FFFF);
    send(ffc_pkg::ActSingleToBf16, 32'h3F80_8000);
    send(ffc_pkg::ActSingleToBf16, 32'h3F81_8000);
    send(ffc_pkg::ActSingleToBf16, 32'h0000_0000);
    for (int i = 0; i < 1450; i++) begin
      if (i == 480) begin
        send_idle_pct = 64;
        recv_idle_pct = 28;
      end else if (i == 960) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      act = ffc_pkg::action_e'($urandom_range(3));
      send(act, random_operand(act));
    end
    req.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
